[src/sbbp_pkg.sv]
// ----------------------------------------------------------------------------
// sbbp_pkg: shared types and codes for the segment buffer bit packer
// Word formats, command codes, status codes and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbbp_pkg;

	// Command codes carried in the func field.
	localparam logic [1:0] FUNC_SET_OFFSET = 2'd0;
	localparam logic [1:0] FUNC_APPEND     = 2'd1;
	localparam logic [1:0] FUNC_PACK       = 2'd2;
	localparam logic [1:0] FUNC_READ       = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BELOW_START = 3'd1;
	localparam logic [2:0] ST_OVER_MAX    = 3'd2;
	localparam logic [2:0] ST_PAST_DATA   = 3'd3;
	localparam logic [2:0] ST_STORE_FULL  = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_SEG_START = 1'b0;
	localparam logic CFG_MAX_SIZE  = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] address;
		logic [7:0]  datum;
		logic [31:0] value;
		logic [5:0]  width;
		logic [2:0]  bit_pos;
		logic        in_place;
		logic [11:0] byte_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] bit_pos_out;
		logic [2:0] status;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic prep;
		logic exec;
		logic rdcap;
		logic rd;
		logic wr_rmw;
		logic put;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] func;
		logic       ok;
		logic       wzero;
		logic       in_place;
		logic       rmw;
		logic       last;
		logic       clr_last;
	} dp_sts_t;

endpackage

[src/sbbp_ctrl.sv]
// ----------------------------------------------------------------------------
// sbbp_ctrl: command sequencer for the segment buffer bit packer
// Runs the clearing pass after reset, steps each command through its
// checks and byte accesses, and owns the output word valid flag.
// ----------------------------------------------------------------------------
module sbbp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  sbbp_pkg::dp_sts_t sts,
	output sbbp_pkg::dp_cmd_t cmd
);
	import sbbp_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PREP  = 4'd2;
	localparam logic [3:0] S_EXEC  = 4'd3;
	localparam logic [3:0] S_RDATA = 4'd4;
	localparam logic [3:0] S_PRD   = 4'd5;
	localparam logic [3:0] S_PWR   = 4'd6;
	localparam logic [3:0] S_PPUT  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.func)
					FUNC_READ: state_d = S_RDATA;
					FUNC_PACK: begin
						if (sts.ok && !sts.wzero) begin
							state_d = sts.rmw ? S_PRD : S_PPUT;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_RDATA: begin
				cmd.rdcap = 1'b1;
				state_d   = S_DONE;
			end
			S_PRD: begin
				cmd.rd  = 1'b1;
				state_d = S_PWR;
			end
			S_PWR: begin
				cmd.wr_rmw = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end else begin
					// Past the first byte only an in-place pack reads back.
					state_d = sts.in_place ? S_PRD : S_PPUT;
				end
			end
			S_PPUT: begin
				cmd.put = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_PREP))
		else $error("accepted word did not start processing");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PWR) |-> ($past(state_q) == S_PRD))
		else $error("read-modify-write without a preceding read");

endmodule

[src/sbbp_datapath.sv]
// ----------------------------------------------------------------------------
// sbbp_datapath: byte store, cursor, fill level and bit packing logic
// Holds the configuration registers, the byte memory with a registered
// read port, the command checks and the result and output registers.
// ----------------------------------------------------------------------------
module sbbp_datapath #(
	parameter int DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [31:0]       cfg_wdata,
	input  sbbp_pkg::in_item_t in_data,
	input  sbbp_pkg::dp_cmd_t  cmd,
	output sbbp_pkg::dp_sts_t  sts,
	output sbbp_pkg::out_item_t out_data
);
	import sbbp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > 13) ? CW : 13) + 1;
	localparam logic [XW-1:0] DEPTH_X   = XW'(DEPTH);
	localparam logic [31:0]   DEPTH_32  = 32'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [31:0]    seg_start_q;
	logic [12:0]    max_size_q;
	logic [CW-1:0]  cursor_q;
	logic [CW-1:0]  fill_q;
	logic [AW-1:0]  clr_q;
	logic [2:0]     k_q;
	in_item_t       item_q;
	logic [5:0]     w_s;
	logic [2:0]     total_s;
	logic [2:0]     bpn_s;
	logic [4:0][7:0] stream_s;
	logic [2:0]     st_q;
	logic [2:0]     bp_q;
	logic [7:0]     rd_q;
	out_item_t      out_q;
	logic [7:0]     mem [DEPTH];
	logic [7:0]     rdata_q;

	// Bit alignment, computed from the latched word.
	logic [5:0]  w_clamp;
	logic [31:0] mask32;
	logic [31:0] vmask;
	logic [6:0]  shamt;
	logic [39:0] stream_n;
	logic [6:0]  tot_sum;

	// Checks.
	logic [XW-1:0] fill_x, cur_x, max_x, idx_x, tot_x, app_n_x, cur_n_x, pk_x;
	logic [31:0]   off;
	logic [2:0]    set_err, app_err, pack_err, status_now;
	logic          ok_now, rmw, put_evt, append_ok;
	logic [CW-1:0] cur_inc;
	logic [AW-1:0] pk_addr;
	logic [7:0]    piece;

	// Memory ports.
	logic          mem_we, mem_re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= '0;
			max_size_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SEG_START: seg_start_q <= cfg_wdata;
				CFG_MAX_SIZE:  max_size_q  <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		w_clamp  = (item_q.width > 6'd32) ? 6'd32 : item_q.width;
		mask32   = (w_clamp >= 6'd32) ? '1 : ((32'd1 << w_clamp) - 32'd1);
		vmask    = item_q.value & mask32;
		// Left-align the field so its top bit lands at bit_pos of byte zero.
		shamt    = 7'd40 - 7'(item_q.bit_pos) - 7'(w_clamp);
		stream_n = {8'd0, vmask} << shamt;
		tot_sum  = 7'(item_q.bit_pos) + 7'(w_clamp) + 7'd7;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.prep) begin
			w_s      <= w_clamp;
			total_s  <= tot_sum[5:3];
			bpn_s    <= item_q.bit_pos + w_clamp[2:0];
			stream_s <= stream_n;
		end
	end

	always_comb begin
		fill_x  = XW'(fill_q);
		cur_x   = XW'(cursor_q);
		max_x   = XW'(max_size_q);
		idx_x   = XW'(item_q.byte_index);
		tot_x   = XW'(total_s);
		off     = item_q.address - seg_start_q;

		if (item_q.address < seg_start_q) begin
			set_err = ST_BELOW_START;
		end else if (max_size_q != '0 && off > 32'(max_size_q)) begin
			set_err = ST_OVER_MAX;
		end else if (off > DEPTH_32) begin
			set_err = ST_STORE_FULL;
		end else begin
			set_err = ST_OK;
		end

		// Bytes that land at the cursor: one for an append; for a pack the
		// first chunk shares the byte before the cursor when mid-byte.
		if (item_q.func == FUNC_APPEND) begin
			app_n_x = XW'(1);
		end else if (item_q.bit_pos == 3'd0) begin
			app_n_x = tot_x;
		end else begin
			app_n_x = tot_x - XW'(1);
		end
		cur_n_x = cur_x + app_n_x;
		if (max_size_q != '0 && cur_n_x > max_x) begin
			app_err = ST_OVER_MAX;
		end else if (cur_n_x > DEPTH_X) begin
			app_err = ST_STORE_FULL;
		end else begin
			app_err = ST_OK;
		end

		if (w_s == 6'd0) begin
			pack_err = ST_OK;
		end else if (item_q.in_place) begin
			pack_err = (idx_x + tot_x - XW'(1) >= fill_x) ? ST_PAST_DATA : ST_OK;
		end else if (item_q.bit_pos != 3'd0 &&
				(cursor_q == '0 || cur_x - XW'(1) >= fill_x)) begin
			pack_err = ST_PAST_DATA;
		end else begin
			pack_err = app_err;
		end

		case (item_q.func)
			FUNC_SET_OFFSET: status_now = set_err;
			FUNC_APPEND:     status_now = app_err;
			FUNC_PACK:       status_now = pack_err;
			default:         status_now = (idx_x >= fill_x) ? ST_PAST_DATA : ST_OK;
		endcase
		ok_now = (status_now == ST_OK);

		rmw = item_q.in_place || (k_q == 3'd0 && item_q.bit_pos != 3'd0);
		if (item_q.in_place) begin
			pk_x = idx_x + XW'(k_q);
		end else if (rmw) begin
			pk_x = cur_x - XW'(1);
		end else begin
			pk_x = cur_x;
		end
		pk_addr = pk_x[AW-1:0];
		piece   = stream_s[3'd4 - k_q];

		append_ok = cmd.exec && item_q.func == FUNC_APPEND && ok_now;
		put_evt   = append_ok || cmd.put;
		cur_inc   = cursor_q + CW'(1);
	end

	always_comb begin
		sts.func     = item_q.func;
		sts.ok       = ok_now;
		sts.wzero    = (w_s == 6'd0);
		sts.in_place = item_q.in_place;
		sts.rmw      = rmw;
		sts.last     = (k_q == total_s - 3'd1);
		sts.clr_last = (clr_q == LAST_ADDR);
	end

	always_comb begin
		mem_we = 1'b1;
		waddr  = pk_addr;
		wdata  = piece;
		if (cmd.clear) begin
			waddr = clr_q;
			wdata = 8'd0;
		end else if (append_ok) begin
			waddr = cursor_q[AW-1:0];
			wdata = item_q.datum;
		end else if (cmd.wr_rmw) begin
			wdata = rdata_q | piece;
		end else if (!cmd.put) begin
			mem_we = 1'b0;
		end
		mem_re = cmd.exec || cmd.rd;
		raddr  = cmd.rd ? pk_addr : idx_x[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			fill_q   <= '0;
			clr_q    <= '0;
			k_q      <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.exec && item_q.func == FUNC_SET_OFFSET && ok_now) begin
				cursor_q <= off[CW-1:0];
			end else if (put_evt) begin
				cursor_q <= cur_inc;
				if (cur_inc > fill_q) begin
					fill_q <= cur_inc;
				end
			end
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.wr_rmw || cmd.put) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q <= status_now;
			bp_q <= (item_q.func == FUNC_PACK && ok_now) ? bpn_s : item_q.bit_pos;
			rd_q <= 8'd0;
		end else if (cmd.rdcap && st_q == ST_OK) begin
			rd_q <= rdata_q;
		end
		if (cmd.out_load) begin
			out_q.read_data   <= rd_q;
			out_q.bit_pos_out <= bp_q;
			out_q.status      <= st_q;
		end
	end

	assign out_data = out_q;

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q <= DEPTH_C) && (fill_q <= DEPTH_C))
		else $error("cursor or fill level beyond the store");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= $past(fill_q))
		else $error("fill level decreased");

	a_rmw_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_rmw |-> (pk_x < fill_x))
		else $error("read-modify-write outside the filled region");

endmodule

[src/segment_buffer_bit_packer.sv]
// ----------------------------------------------------------------------------
// segment_buffer_bit_packer: segment byte store with an MSB-first bit packer
// Takes set-offset, append, pack and read commands against a byte store
// with a write cursor and a fill level, one result word per command.
//
// Channel  Dir  Handshake              Payload
// cfg      in   cfg_we                 cfg_idx, cfg_wdata
// in       in   in_valid / in_stall    sbbp_pkg::in_item_t
// out      out  out_valid / out_stall  sbbp_pkg::out_item_t
//
// One command is processed at a time. Each command is latched, prepared and
// checked, a read then captures its byte, and a pack writes its bytes one by
// one: a single write for each appended byte and a read and a write for each
// read-modify-write byte, set by the single write and single registered read
// port of the store. After reset a clearing pass zeroes the store, one byte a
// cycle, while in_stall is high. The next command is taken while a result
// waits in the output register; a stalled output holds the block in its
// final step until the word is taken.
// ----------------------------------------------------------------------------
module segment_buffer_bit_packer #(
	parameter int DEPTH = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  sbbp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sbbp_pkg::out_item_t out_data
);
	import sbbp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	sbbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbbp_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for segment_buffer_bit_packer
// Drives set-offset, append, pack and read commands through the valid/stall
// channel. A behavioral copy of the byte store, cursor and fill level predicts
// every result word, and each word taken from the block is compared with it.
// ----------------------------------------------------------------------------
module tb;
	import sbbp_pkg::*;

	localparam int DEPTH          = 4096;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_REPORTS    = 40;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_idx   = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;

	// Predicted state of the block.
	logic [7:0]  seg_bytes [DEPTH];
	logic [31:0] seg_base   = '0;
	int unsigned size_limit = 0;
	int unsigned wr_cursor  = 0;
	int unsigned filled     = 0;

	out_item_t   expected_words [$];
	logic [2:0]  next_bit_pos = 3'd0;
	int          send_pct     = 0;
	int          stall_pct    = 0;
	logic        out_hold     = 1'b0;
	event        hold_results;
	int          errors       = 0;
	int          n_sent       = 0;
	int          n_packs      = 0;
	int          n_rejected   = 0;
	int          n_checked    = 0;
	int          quiet_cycles = 0;

	segment_buffer_bit_packer #(.DEPTH(DEPTH)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [2:0] room_for(input int unsigned n);
		if (size_limit != 0 && wr_cursor + n > size_limit)
			return ST_OVER_MAX;
		if (wr_cursor + n > DEPTH)
			return ST_STORE_FULL;
		return ST_OK;
	endfunction

	function automatic void put_byte(input logic [7:0] d);
		seg_bytes[wr_cursor] = d;
		wr_cursor++;
		if (wr_cursor > filled)
			filled = wr_cursor;
	endfunction

	function automatic out_item_t segment_step(input in_item_t cmd);
		out_item_t   res;
		int unsigned w, b, total, k, room, offs;
		logic [31:0] v, chunk;
		logic        fresh;
		res.read_data   = 8'd0;
		res.bit_pos_out = cmd.bit_pos;
		res.status      = ST_OK;
		case (cmd.func)
		FUNC_SET_OFFSET: begin
			if (cmd.address < seg_base) begin
				res.status = ST_BELOW_START;
			end else begin
				offs = cmd.address - seg_base;
				if (size_limit != 0 && offs > size_limit)
					res.status = ST_OVER_MAX;
				else if (offs > DEPTH)
					res.status = ST_STORE_FULL;
				else
					wr_cursor = offs;
			end
		end
		FUNC_APPEND: begin
			res.status = room_for(1);
			if (res.status == ST_OK)
				put_byte(cmd.datum);
		end
		FUNC_PACK: begin
			w = (cmd.width > 6'd32) ? 32'd32 : 32'(cmd.width);
			b = 32'(cmd.bit_pos);
			if (w != 0) begin
				v = (w == 32) ? cmd.value : (cmd.value & ((32'd1 << w) - 32'd1));
				total = (b + w + 7) / 8;
				// All checks come first; a rejected pack leaves the store untouched.
				if (cmd.in_place) begin
					if (cmd.byte_index + total - 1 >= filled)
						res.status = ST_PAST_DATA;
				end else if (b != 0 && (wr_cursor == 0 || wr_cursor - 1 >= filled)) begin
					res.status = ST_PAST_DATA;
				end else begin
					res.status = room_for((b == 0) ? total : total - 1);
				end
				if (res.status == ST_OK) begin
					k = 0;
					while (w > 0) begin
						room  = 8 - b;
						fresh = (b == 0);
						if (room > w) begin
							chunk = (v & ((32'd1 << w) - 32'd1)) << (room - w);
							b += w;
							w = 0;
						end else begin
							chunk = (v >> (w - room)) & ((32'd1 << room) - 32'd1);
							w -= room;
							b = 0;
						end
						if (cmd.in_place)
							seg_bytes[cmd.byte_index + k] |= chunk[7:0];
						else if (fresh)
							put_byte(chunk[7:0]);
						else
							seg_bytes[wr_cursor - 1] |= chunk[7:0];
						k++;
					end
					res.bit_pos_out = b[2:0];
				end
			end
		end
		default: begin
			if (cmd.byte_index >= filled)
				res.status = ST_PAST_DATA;
			else
				res.read_data = seg_bytes[cmd.byte_index];
		end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_word(input in_item_t cmd);
		out_item_t res;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= cmd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = segment_step(cmd);
		expected_words = {expected_words, res};
		n_sent++;
		if (cmd.func == FUNC_PACK)
			n_packs++;
		if (res.status != ST_OK)
			n_rejected++;
		else if (cmd.func == FUNC_PACK)
			next_bit_pos = res.bit_pos_out;
		else if (cmd.func != FUNC_READ)
			next_bit_pos = 3'd0;
	endtask

	// Fields that a command does not use still carry random bits.
	function automatic in_item_t noise_cmd(input logic [1:0] f);
		in_item_t c;
		c      = {$urandom, $urandom, $urandom};
		c.func = f;
		return c;
	endfunction

	task automatic send_offset(input logic [31:0] addr);
		in_item_t c;
		c         = noise_cmd(FUNC_SET_OFFSET);
		c.address = addr;
		send_word(c);
	endtask

	task automatic send_append(input logic [7:0] d);
		in_item_t c;
		c       = noise_cmd(FUNC_APPEND);
		c.datum = d;
		send_word(c);
	endtask

	task automatic send_pack(input logic [31:0] val, input logic [5:0] wd,
			input logic [2:0] bp, input logic inpl, input logic [11:0] idx);
		in_item_t c;
		c            = noise_cmd(FUNC_PACK);
		c.value      = val;
		c.width      = wd;
		c.bit_pos    = bp;
		c.in_place   = inpl;
		c.byte_index = idx;
		send_word(c);
	endtask

	task automatic send_read(input logic [11:0] idx);
		in_item_t c;
		c            = noise_cmd(FUNC_READ);
		c.byte_index = idx;
		send_word(c);
	endtask

	// Mostly an index near the filled region, now and then anywhere.
	function automatic logic [11:0] near_fill(input int unsigned extra);
		int unsigned top;
		top = filled + extra;
		if (top > DEPTH - 1 || $urandom_range(9) == 0)
			top = DEPTH - 1;
		return 12'($urandom_range(top));
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] seg, input int unsigned lim);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_SEG_START;
		cfg_wdata <= seg;
		@(posedge clk);
		cfg_idx   <= CFG_MAX_SIZE;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we    <= 1'b0;
		seg_base   = seg;
		size_limit = lim & 32'h1fff;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_pct  = 0;
		stall_pct = 0;
		set_config(32'h0000_1000, 16);
		send_read(12'd0);
		send_pack(32'hffff_ffff, 6'd8, 3'd0, 1'b1, 12'd0);
		send_pack(32'h0000_001f, 6'd5, 3'd3, 1'b0, 12'd0);
		send_offset(32'h0000_0fff);
		send_offset(32'h0000_1011);
		send_offset(32'h0000_1010);
		send_append(8'ha5);
		send_offset(32'h0000_1002);
		// The first bytes of the segment are skipped and must read back as zero.
		send_append(8'hff);
		send_read(12'd0);
		send_read(12'd2);
		send_pack(32'hdead_beef, 6'd32, 3'd0, 1'b0, 12'd0);
		send_pack(32'hffff_fffd, 6'd3, 3'd0, 1'b0, 12'd0);
		send_pack(32'h1234_5678, 6'd63, 3'd3, 1'b0, 12'd0);
		send_pack(32'hffff_ffff, 6'd0, 3'd5, 1'b0, 12'd0);
		send_pack(32'h0000_03ff, 6'd10, 3'd1, 1'b1, 12'd0);
		send_pack(32'h0000_01ff, 6'd9, 3'd6, 1'b1, 12'd11);
		send_pack(32'h8000_0001, 6'd32, 3'd0, 1'b0, 12'd0);
		send_pack(32'h0000_0001, 6'd1, 3'd0, 1'b0, 12'd0);
		send_read(12'd4095);
		send_read(12'd15);
		drain();
		set_config(32'hffff_ffff, 0);
		send_offset(32'hffff_ffff);
		send_offset(32'hffff_fffe);
		drain();
		set_config(32'h0000_0000, 0);
		send_offset(32'd4097);
		send_offset(32'd4093);
		send_pack(32'hffff_ffff, 6'd32, 3'd0, 1'b0, 12'd0);
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int hold_pct,
			input logic [31:0] seg, input int unsigned lim);
		int unsigned sel, top;
		logic [2:0]  bp;
		logic [5:0]  wd;
		drain();
		set_config(seg, lim);
		send_pct  = idle_pct;
		stall_pct = hold_pct;
		repeat (n) begin
			sel = $urandom_range(99);
			// Pull the cursor back now and then so the store stays small.
			if (sel < 12 || wr_cursor > 96) begin
				top = (filled < 56) ? filled + 8 : 64;
				if (size_limit != 0 && top > size_limit)
					top = size_limit;
				case ($urandom_range(7))
				0: send_offset($urandom);
				1: send_offset(seg_base + size_limit + $urandom_range(1));
				2: send_offset(seg_base - $urandom_range(1, 3));
				default: send_offset(seg_base + $urandom_range(top));
				endcase
			end else if (sel < 40) begin
				send_append(8'($urandom));
			end else if (sel < 75) begin
				// Most packs continue the bit stream where the last one stopped.
				bp = ($urandom_range(3) != 0) ? next_bit_pos : 3'($urandom_range(7));
				wd = ($urandom_range(9) != 0) ? 6'($urandom_range(1, 32))
					: 6'($urandom_range(63));
				if ($urandom_range(3) == 0)
					send_pack($urandom, wd, bp, 1'b1, near_fill(2));
				else
					send_pack($urandom, wd, bp, 1'b0, 12'($urandom));
			end else begin
				send_read(near_fill(3));
			end
		end
	endtask

	// The output is held off while words keep coming, so the block backs up.
	task automatic test_backpressure();
		drain();
		send_pct  = 0;
		stall_pct = 0;
		-> hold_results;
		repeat (40) begin
			if ($urandom_range(1) == 0)
				send_append(8'($urandom));
			else
				send_read(near_fill(0));
		end
	endtask

	task automatic test_store_end();
		drain();
		set_config(32'h0000_0000, 0);
		send_offset(32'd4096);
		send_append(8'h3c);
		send_pack(32'h0000_00ff, 6'd8, 3'd0, 1'b0, 12'd0);
		send_offset(32'd4095);
		send_append(8'h5a);
		send_read(12'd4095);
		send_read(12'd4094);
		send_pack(32'h0000_0081, 6'd8, 3'd0, 1'b1, 12'd4095);
		send_pack(32'h0000_01ff, 6'd9, 3'd0, 1'b1, 12'd4095);
		// The cursor now sits at the end of the store; only the last byte can take bits.
		send_pack(32'h0000_0015, 6'd6, 3'd2, 1'b0, 12'd0);
		send_pack(32'h0000_0055, 6'd7, 3'd2, 1'b0, 12'd0);
		send_append(8'h01);
		send_read(12'd4095);
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------
	always @(posedge clk)
		out_stall <= out_hold || ($urandom_range(99) < stall_pct);

	always begin
		@(hold_results);
		out_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		out_hold <= 1'b0;
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("%0t: result word %h with none expected", $time, out_data);
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("read_data", 32'(want.read_data), 32'(out_data.read_data));
				check_field("bit_pos_out", 32'(want.bit_pos_out),
					32'(out_data.bit_pos_out));
				check_field("status", 32'(want.status), 32'(out_data.status));
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		foreach (seg_bytes[i])
			seg_bytes[i] = 8'h00;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_traffic(225, 0, 0, $urandom >> 1, 0);
		test_random_traffic(225, 85, 0, $urandom >> 1, $urandom_range(24, 200));
		test_random_traffic(225, 0, 85, 32'd0, 4096);
		test_random_traffic(225, 15, 15, $urandom >> 1, $urandom_range(8, 40));
		test_backpressure();
		test_store_end();
		drain();
		$display("Summary: %0d commands taken (%0d packs), %0d result words checked, %0d refused.",
			n_sent, n_packs, n_checked, n_rejected);
		$display("Covered corner cases, four pacing mixes, a long output hold and the store end.");
		if (errors == 0 && expected_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[segment_buffer_bit_packer.f]
src/sbbp_pkg.sv
src/sbbp_ctrl.sv
src/sbbp_datapath.sv
src/segment_buffer_bit_packer.sv
test/tb.sv
